FILE: hw/rtl/quantized_q4_q8_block_dot_macros.svh
// ----------------------------------------------------------------------------
// Q4/Q8 block dot product: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QUANTIZED_Q4_Q8_BLOCK_DOT_MACROS_SVH
`define QUANTIZED_Q4_Q8_BLOCK_DOT_MACROS_SVH

// Same-cycle implication.
`define QDOT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QDOT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/qdot_pkg.sv
// ----------------------------------------------------------------------------
// Q4/Q8 block dot product: package
// Types, constants and single-precision helper functions.
// ----------------------------------------------------------------------------
package qdot_pkg;

  localparam int LANES       = 4;
  localparam int BYTE_W      = 8;
  localparam int NIB_W       = 4;
  localparam int LANE_SUM_W  = 13;
  localparam int ITEM_SUM_W  = 15;
  localparam int EXP_W       = 12;

  localparam logic signed [4:0]       NIB_OFFSET  = 5'sd8;
  localparam logic [31:0]             DEFAULT_NAN = 32'h7FC0_0000;
  localparam logic signed [EXP_W-1:0] EXP_BIAS    = 12'sd127;
  // Exponent given to zero operands so that they always align below the other.
  localparam logic signed [EXP_W-1:0] ZERO_EXP    = -12'sd1024;

  // Unpacked float: value = sig / 2^47 * 2^exp, sig normalized with bit 47 set.
  typedef struct packed {
    logic                    sign;
    logic                    nan;
    logic                    inf;
    logic                    zero;
    logic signed [EXP_W-1:0] exp;
    logic [47:0]             sig;
  } fp_unp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_UNPK,
    ST_MUL,
    ST_MUL_RND,
    ST_FMA_UNPK,
    ST_FMA_MUL,
    ST_FMA_NORM,
    ST_RED,
    ST_ADD_ALIGN,
    ST_ADD_SUM,
    ST_ADD_NORM,
    ST_ADD_RND,
    ST_OUT
  } fpu_state_t;

  typedef enum logic [1:0] {
    OP_FMA,
    OP_R01,
    OP_R23,
    OP_RFIN
  } fpu_op_t;

  typedef struct packed {
    logic start;
    logic vend;
  } fpu_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } fpu_sts_t;

  // Leading zero count of a 64-bit word; 64 when the word is zero.
  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [6:0] n;
    logic       found;
    n = 7'd64;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 7'(63 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Splits an fp32 pattern into flags and a normalized significand.
  function automatic fp_unp_t fp_unpack(input logic [31:0] b);
    fp_unp_t    u;
    logic [7:0] e;
    logic [22:0] f;
    logic [6:0] lz;
    e = b[30:23];
    f = b[22:0];
    lz = lzc64({f, 41'd0});
    u.sign = b[31];
    u.nan  = (e == 8'hFF) && (f != '0);
    u.inf  = (e == 8'hFF) && (f == '0);
    u.zero = (e == 8'd0) && (f == '0);
    if (u.zero) begin
      u.sig = '0;
      u.exp = ZERO_EXP;
    end else if (e != 8'd0) begin
      u.sig = {1'b1, f, 24'd0};
      u.exp = $signed({4'd0, e}) - EXP_BIAS;
    end else begin
      u.sig = {f, 25'd0} << lz;
      u.exp = -EXP_BIAS - $signed({5'd0, lz});
    end
    return u;
  endfunction

  // Rounds a finite nonzero value to fp32, nearest even, with subnormals.
  function automatic logic [31:0] fp_round(input logic sign,
                                           input logic signed [EXP_W-1:0] exp,
                                           input logic [47:0] sig);
    logic signed [12:0] be;
    logic [12:0]        sh;
    logic [47:0]        sv;
    logic               st;
    logic               rnd;
    logic [30:0]        r;
    be  = {exp[EXP_W-1], exp} + 13'sd127;
    sh  = '0;
    sv  = '0;
    st  = 1'b0;
    rnd = 1'b0;
    if (be >= 13'sd255) begin
      r = {8'hFF, 23'd0};
    end else if (be >= 13'sd1) begin
      rnd = sig[23] & ((|sig[22:0]) | sig[24]);
      r = {be[7:0], sig[46:24]} + 31'(rnd);
    end else begin
      sh = 13'(13'sd1 - be);
      if (sh >= 13'd48) begin
        sv = '0;
        st = |sig;
      end else begin
        sv = sig >> sh[5:0];
        st = |(sig & ~({48{1'b1}} << sh[5:0]));
      end
      rnd = sv[23] & (st | (|sv[22:0]) | sv[24]);
      r = {8'd0, sv[46:24]} + 31'(rnd);
    end
    return {sign, r};
  endfunction

endpackage

FILE: hw/rtl/qdot_if.sv
// ----------------------------------------------------------------------------
// Q4/Q8 block dot product: channel interfaces
// Valid/ready channels for input requests and dot product results.
// ----------------------------------------------------------------------------
interface qdot_item_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_nibble_bytes;
  logic [31:0] y_low_quants;
  logic [31:0] y_high_quants;
  logic [31:0] x_scale_bits;
  logic [31:0] y_scale_bits;
  logic        vector_end;

  modport source(output valid, x_nibble_bytes, y_low_quants, y_high_quants,
                 x_scale_bits, y_scale_bits, vector_end, input ready);
  modport sink(input valid, x_nibble_bytes, y_low_quants, y_high_quants,
               x_scale_bits, y_scale_bits, vector_end, output ready);
endinterface

interface qdot_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] dot_result_bits;

  modport source(output valid, dot_result_bits, input ready);
  modport sink(input valid, dot_result_bits, output ready);
endinterface

FILE: hw/rtl/quantized_q4_q8_block_dot.sv
// An item that does not close a block is accepted whenever the float sequencer is idle.
// An item that closes a block stalls the input while the sequencer runs the scale multiply and fused add.
// On vector end the input stays stalled until the result is released; after the fused add,
// three lane additions on the shared adder pipeline run before the result is offered.
// Reset (synchronous, active high) clears block sum, counters and lane accumulators.
// ----------------------------------------------------------------------------
// Q4/Q8 block dot product: top level
// Four product lanes and a merge tree build each request's integer sum; a
// float sequencer folds finished blocks into four lane accumulators.
// ----------------------------------------------------------------------------
`include "quantized_q4_q8_block_dot_macros.svh"

module quantized_q4_q8_block_dot import qdot_pkg::*; #(
  parameter int BLOCK_SIZE = 32
) (
  input  logic          clk,
  input  logic          rst,
  qdot_item_if.sink     items,
  qdot_result_if.source results
);

  localparam int ITEMS = BLOCK_SIZE / 8;
  localparam int CNT_W = $clog2(ITEMS);
  localparam int SUM_W = $clog2(BLOCK_SIZE * 1024 + 1) + 1;

  logic signed [LANE_SUM_W-1:0] lane_sum [LANES];
  logic signed [ITEM_SUM_W-1:0] item_sum;
  logic signed [SUM_W-1:0]      partial;
  logic signed [SUM_W-1:0]      partial_next;
  logic [CNT_W-1:0]             cnt;
  logic                         accept;
  logic                         closing;
  logic                         out_valid;
  logic [31:0]                  out_bits;
  logic [31:0]                  fpu_bits;
  logic                         res_free;
  fpu_ctl_t                     ctl;
  fpu_sts_t                     sts;

  // Product lanes, one per packed byte.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    qdot_lane u_lane (
      .x_byte   (items.x_nibble_bytes[BYTE_W*g +: BYTE_W]),
      .y_lo     (items.y_low_quants[BYTE_W*g +: BYTE_W]),
      .y_hi     (items.y_high_quants[BYTE_W*g +: BYTE_W]),
      .lane_sum (lane_sum[g])
    );
  end

  // Merge the lanes and extend the running block sum.
  assign item_sum = (ITEM_SUM_W'(lane_sum[0]) + ITEM_SUM_W'(lane_sum[1]))
                  + (ITEM_SUM_W'(lane_sum[2]) + ITEM_SUM_W'(lane_sum[3]));
  assign partial_next = partial + SUM_W'(item_sum);

  // Handshake and block boundary.
  assign items.ready = sts.idle;
  assign accept      = items.valid && items.ready;
  assign closing     = (cnt == CNT_W'(ITEMS - 1)) || items.vector_end;
  assign ctl.start   = accept && closing;
  assign ctl.vend    = items.vector_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      partial <= '0;
    end else if (accept) begin
      if (closing) begin
        cnt     <= '0;
        partial <= '0;
      end else begin
        cnt     <= cnt + CNT_W'(1);
        partial <= partial_next;
      end
    end
  end

  qdot_fpu #(
    .SUM_W (SUM_W)
  ) u_fpu (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .blk_sum  (partial_next),
    .x_scale  (items.x_scale_bits),
    .y_scale  (items.y_scale_bits),
    .res_free (res_free),
    .sts      (sts),
    .res_bits (fpu_bits)
  );

  // Output register.
  assign res_free = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sts.done) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.done) out_bits <= fpu_bits;
  end

  assign results.valid           = out_valid;
  assign results.dot_result_bits = out_bits;

  // A block-closing request must start the float sequence.
  `QDOT_ASSERT_NXT(a_close_starts, accept && closing, !sts.idle, "block close did not start")
  // A result is only released when the output register can take it.
  `QDOT_ASSERT_IMP(a_done_room, sts.done, !out_valid || results.ready, "result overwrite")
  // Requests inside a block step the item counter by one.
  `QDOT_ASSERT_NXT(a_cnt_step, accept && !closing, cnt == $past(cnt) + CNT_W'(1), "count slip")

endmodule

FILE: hw/rtl/qdot_lane.sv
// ----------------------------------------------------------------------------
// Q4/Q8 block dot product: product lane
// One packed byte of 4-bit quants times its two signed 8-bit partners.
// ----------------------------------------------------------------------------
module qdot_lane import qdot_pkg::*; (
  input  logic [BYTE_W-1:0]            x_byte,
  input  logic [BYTE_W-1:0]            y_lo,
  input  logic [BYTE_W-1:0]            y_hi,
  output logic signed [LANE_SUM_W-1:0] lane_sum
);

  logic signed [NIB_W:0]          lo_q;
  logic signed [NIB_W:0]          hi_q;
  logic signed [LANE_SUM_W-1:0]   p_lo;
  logic signed [LANE_SUM_W-1:0]   p_hi;

  // Remove the nibble offset to get signed quants.
  assign lo_q = $signed({1'b0, x_byte[NIB_W-1:0]}) - NIB_OFFSET;
  assign hi_q = $signed({1'b0, x_byte[BYTE_W-1:NIB_W]}) - NIB_OFFSET;

  // Two exact products and their sum.
  assign p_lo = lo_q * $signed(y_lo);
  assign p_hi = hi_q * $signed(y_hi);
  assign lane_sum = p_lo + p_hi;

endmodule

FILE: hw/rtl/qdot_fpu.sv
// ----------------------------------------------------------------------------
// Q4/Q8 block dot product: float sequencer
// Scales a block sum into its lane accumulator with a fused multiply-add and
// reduces the four lanes to the final fp32 result.
// ----------------------------------------------------------------------------
module qdot_fpu import qdot_pkg::*; #(
  parameter int SUM_W = 17
) (
  input  logic                    clk,
  input  logic                    rst,
  input  fpu_ctl_t                ctl,
  input  logic signed [SUM_W-1:0] blk_sum,
  input  logic [31:0]             x_scale,
  input  logic [31:0]             y_scale,
  input  logic                    res_free,
  output fpu_sts_t                sts,
  output logic [31:0]             res_bits
);

  localparam int MAG_W = SUM_W - 1;
  localparam int PW    = 24 + MAG_W;

  fpu_state_t state;
  fpu_state_t state_next;
  fpu_op_t    op;

  logic                    vend_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [31:0]             dx_q;
  logic [31:0]             dy_q;
  logic [1:0]              lane_q;
  logic [31:0]             acc [LANES];
  logic [31:0]             tmp0;
  logic [31:0]             tmp1;

  logic acc_we;
  logic red_we;

  // Multiply stage registers.
  fp_unp_t                 ux;
  fp_unp_t                 uy;
  logic [47:0]             prod;
  logic signed [EXP_W-1:0] mexp;
  logic                    ms;
  logic                    m_nan;
  logic                    m_inf;
  logic                    m_zero;
  logic [31:0]             scale_bits;

  // Fused product stage registers.
  fp_unp_t                 us;
  logic                    sneg;
  logic                    szero;
  logic [MAG_W-1:0]        mag;
  logic [PW-1:0]           pp;

  // Adder stage registers.
  fp_unp_t                 opa;
  fp_unp_t                 opb;
  fp_unp_t                 opa_next;
  fp_unp_t                 opb_next;
  logic [51:0]             al_fa;
  logic [51:0]             al_fb;
  logic signed [EXP_W-1:0] al_exp;
  logic                    al_sign;
  logic                    al_sub;
  logic                    al_bzero;
  logic                    al_zsign;
  logic                    al_spec;
  logic [31:0]             al_sbits;
  logic [51:0]             s52;
  logic signed [EXP_W-1:0] s_exp;
  logic                    s_sign;
  logic                    s_bzero;
  logic                    s_zsign;
  logic                    s_spec;
  logic [31:0]             s_sbits;
  logic [47:0]             n_sig;
  logic signed [EXP_W-1:0] n_exp;
  logic                    n_sign;
  logic                    n_zero;
  logic                    n_bzero;
  logic                    n_zsign;
  logic                    n_spec;
  logic [31:0]             n_sbits;
  logic [31:0]             add_bits;

  // Combinational helpers.
  logic [6:0]              lzp;
  fp_unp_t                 pu;
  fp_unp_t                 big;
  fp_unp_t                 sml;
  logic signed [EXP_W:0]   dexp;
  logic [51:0]             fbf;
  logic [51:0]             fb_sh;
  logic                    fb_st;
  logic [6:0]              lzn;
  logic [51:0]             norm;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (ctl.start) state_next = ST_MUL_UNPK;
      ST_MUL_UNPK:  state_next = ST_MUL;
      ST_MUL:       state_next = ST_MUL_RND;
      ST_MUL_RND:   state_next = ST_FMA_UNPK;
      ST_FMA_UNPK:  state_next = ST_FMA_MUL;
      ST_FMA_MUL:   state_next = ST_FMA_NORM;
      ST_FMA_NORM:  state_next = ST_ADD_ALIGN;
      ST_RED:       state_next = ST_ADD_ALIGN;
      ST_ADD_ALIGN: state_next = ST_ADD_SUM;
      ST_ADD_SUM:   state_next = ST_ADD_NORM;
      ST_ADD_NORM:  state_next = ST_ADD_RND;
      ST_ADD_RND: begin
        unique case (op)
          OP_FMA:  state_next = vend_q ? ST_RED : ST_IDLE;
          OP_R01:  state_next = ST_RED;
          OP_R23:  state_next = ST_RED;
          OP_RFIN: state_next = ST_OUT;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_OUT:       if (res_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Status and write enables.
  always_comb begin
    sts.idle = (state == ST_IDLE);
    sts.done = (state == ST_OUT) && res_free;
    acc_we   = (state == ST_ADD_RND) && (op == OP_FMA);
    red_we   = (state == ST_ADD_RND) && (op != OP_FMA);
  end

  // Control state: sequencer, operation, lane pointer and accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      op     <= OP_FMA;
      vend_q <= 1'b0;
      lane_q <= '0;
      for (int k = 0; k < LANES; k++) acc[k] <= '0;
    end else begin
      state <= state_next;
      if (sts.idle && ctl.start) begin
        op     <= OP_FMA;
        vend_q <= ctl.vend;
      end
      if (acc_we) begin
        acc[lane_q] <= add_bits;
        lane_q      <= lane_q + 2'd1;
        op          <= OP_R01;
      end
      if (red_we) begin
        unique case (op)
          OP_R01:  op <= OP_R23;
          OP_R23:  op <= OP_RFIN;
          OP_RFIN: op <= OP_FMA;
          default: op <= OP_FMA;
        endcase
      end
      if (sts.done) begin
        vend_q <= 1'b0;
        lane_q <= '0;
        for (int k = 0; k < LANES; k++) acc[k] <= '0;
      end
    end
  end

  // Command capture and reduction temporaries.
  always_ff @(posedge clk) begin
    if (sts.idle && ctl.start) begin
      sum_q <= blk_sum;
      dx_q  <= x_scale;
      dy_q  <= y_scale;
    end
    if (red_we) begin
      unique case (op)
        OP_R01:  tmp0 <= add_bits;
        OP_R23:  tmp1 <= add_bits;
        OP_RFIN: res_bits <= add_bits;
        default: tmp0 <= add_bits;
      endcase
    end
  end

  // Scale product dx*dy, rounded to single.
  always_ff @(posedge clk) begin
    if (state == ST_MUL_UNPK) begin
      ux <= fp_unpack(dx_q);
      uy <= fp_unpack(dy_q);
    end
    if (state == ST_MUL) begin
      prod   <= ux.sig[47:24] * uy.sig[47:24];
      mexp   <= ux.exp + uy.exp;
      ms     <= ux.sign ^ uy.sign;
      m_nan  <= ux.nan | uy.nan | (ux.inf & uy.zero) | (ux.zero & uy.inf);
      m_inf  <= ux.inf | uy.inf;
      m_zero <= ux.zero | uy.zero;
    end
    if (state == ST_MUL_RND) begin
      if (m_nan) scale_bits <= DEFAULT_NAN;
      else if (m_inf) scale_bits <= {ms, 8'hFF, 23'd0};
      else if (m_zero) scale_bits <= {ms, 31'd0};
      else if (prod[47]) scale_bits <= fp_round(ms, mexp + 12'sd1, prod);
      else scale_bits <= fp_round(ms, mexp, {prod[46:0], 1'b0});
    end
  end

  // Exact product of the scale and the block sum.
  always_ff @(posedge clk) begin
    if (state == ST_FMA_UNPK) begin
      us    <= fp_unpack(scale_bits);
      sneg  <= sum_q[SUM_W-1];
      szero <= (sum_q == '0);
      mag   <= sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
    end
    if (state == ST_FMA_MUL) begin
      pp <= us.sig[47:24] * mag;
    end
  end

  // Normalize the exact product into an adder operand.
  always_comb begin
    lzp     = lzc64({pp, {(64 - PW){1'b0}}});
    pu.sign = us.sign ^ sneg;
    pu.nan  = us.nan | (us.inf & szero);
    pu.inf  = us.inf & !szero;
    pu.zero = us.zero | szero;
    if (pu.zero) begin
      pu.sig = '0;
      pu.exp = ZERO_EXP;
    end else begin
      pu.sig = 48'(pp) << (7'(48 - PW) + lzp);
      pu.exp = us.exp + $signed(12'(MAG_W)) - $signed({5'd0, lzp});
    end
  end

  // Adder operand selection.
  always_comb begin
    if (state == ST_FMA_NORM) begin
      opa_next = pu;
      opb_next = fp_unpack(acc[lane_q]);
    end else begin
      unique case (op)
        OP_R01: begin
          opa_next = fp_unpack(acc[0]);
          opb_next = fp_unpack(acc[1]);
        end
        OP_R23: begin
          opa_next = fp_unpack(acc[2]);
          opb_next = fp_unpack(acc[3]);
        end
        default: begin
          opa_next = fp_unpack(tmp0);
          opb_next = fp_unpack(tmp1);
        end
      endcase
    end
  end

  // Alignment: larger magnitude on top, smaller shifted with sticky.
  always_comb begin
    if ((opa.exp > opb.exp) || ((opa.exp == opb.exp) && (opa.sig >= opb.sig))) begin
      big = opa;
      sml = opb;
    end else begin
      big = opb;
      sml = opa;
    end
    dexp = {big.exp[EXP_W-1], big.exp} - {sml.exp[EXP_W-1], sml.exp};
    fbf  = {1'b0, sml.sig, 3'b000};
    if (dexp >= 13'sd52) begin
      fb_sh = '0;
      fb_st = |sml.sig;
    end else begin
      fb_sh = fbf >> dexp[5:0];
      fb_st = |(fbf & ~({52{1'b1}} << dexp[5:0]));
    end
  end

  // Normalization of the raw sum.
  always_comb begin
    lzn  = lzc64({s52, 12'd0});
    norm = s52 << lzn;
  end

  // Adder pipeline, one stage per state.
  always_ff @(posedge clk) begin
    if ((state == ST_FMA_NORM) || (state == ST_RED)) begin
      opa <= opa_next;
      opb <= opb_next;
    end
    if (state == ST_ADD_ALIGN) begin
      al_fa    <= {1'b0, big.sig, 3'b000};
      al_fb    <= {fb_sh[51:1], fb_sh[0] | fb_st};
      al_exp   <= big.exp;
      al_sign  <= big.sign;
      al_sub   <= big.sign ^ sml.sign;
      al_bzero <= opa.zero & opb.zero;
      al_zsign <= opa.sign & opb.sign;
      al_spec  <= opa.nan | opb.nan | opa.inf | opb.inf;
      if (opa.nan | opb.nan | (opa.inf & opb.inf & (opa.sign != opb.sign)))
        al_sbits <= DEFAULT_NAN;
      else
        al_sbits <= {opa.inf ? opa.sign : opb.sign, 8'hFF, 23'd0};
    end
    if (state == ST_ADD_SUM) begin
      s52     <= al_sub ? (al_fa - al_fb) : (al_fa + al_fb);
      s_exp   <= al_exp;
      s_sign  <= al_sign;
      s_bzero <= al_bzero;
      s_zsign <= al_zsign;
      s_spec  <= al_spec;
      s_sbits <= al_sbits;
    end
    if (state == ST_ADD_NORM) begin
      n_sig   <= {norm[51:5], |norm[4:0]};
      n_exp   <= s_exp + 12'sd1 - $signed({5'd0, lzn});
      n_sign  <= s_sign;
      n_zero  <= (s52 == '0);
      n_bzero <= s_bzero;
      n_zsign <= s_zsign;
      n_spec  <= s_spec;
      n_sbits <= s_sbits;
    end
  end

  // Final rounding of the sum; an exact zero is positive unless both were negative zeros.
  always_comb begin
    if (n_spec) add_bits = n_sbits;
    else if (n_zero) add_bits = {n_bzero & n_zsign, 31'd0};
    else add_bits = fp_round(n_sign, n_exp, n_sig);
  end

endmodule

FILE: dv/tb_quantized_q4_q8_block_dot.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Q4/Q8 block dot product: testbench
// Streams 4-bit/8-bit quantized block requests with their fp32 scales and
// predicts each vector's single-precision dot product. Every returned result
// is compared with the oldest prediction, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_quantized_q4_q8_block_dot import qdot_pkg::*;;

  localparam int ITEMS_PER_BLK = 32 / 8;

  // Scoreboard: carries its own copy of the block state and predicts results.
  class dot_scoreboard;
    int          blk_sum;
    int          item_idx;
    int          lane_idx;
    logic [31:0] lane_acc[LANES];
    logic [31:0] dot_q[$];
    int          fails;
    int          seen;

    function new();
      fails = 0;
      seen = 0;
      clear_state();
    endfunction

    function void clear_state();
      blk_sum = 0;
      item_idx = 0;
      lane_idx = 0;
      for (int k = 0; k < LANES; k++) lane_acc[k] = 32'h0;
    endfunction

    function int pending();
      return dot_q.size();
    endfunction

    // Widens an fp32 pattern to a real without loss.
    function real single_to_real(logic [31:0] b);
      logic [63:0] d;
      real         mag;
      if (b[30:23] == 8'hFF) begin
        d = {b[31], 11'h7FF, b[22:0], 29'd0};
      end else if (b[30:0] == 31'd0) begin
        d = {b[31], 63'd0};
      end else if (b[30:23] == 8'd0) begin
        mag = real'(b[22:0]) * (2.0 ** (-149));
        d = $realtobits(mag);
        d[63] = b[31];
      end else begin
        d = {b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0};
      end
      return $bitstoreal(d);
    endfunction

    // Rounds a double to fp32, nearest even, subnormals kept, NaN made quiet.
    function logic [31:0] real_to_single(real r);
      logic [63:0] d;
      logic [52:0] sig;
      logic [52:0] field;
      int          ue;
      int          be;
      int          sa;
      logic        rbit;
      logic        sticky;
      logic        rnd;
      d = $realtobits(r);
      sig = {1'b1, d[51:0]};
      ue = int'(d[62:52]) - 1023;
      be = ue + 127;
      if (d[62:52] == 11'h7FF) begin
        if (d[51:0] != 0) return DEFAULT_NAN;
        return {d[63], 8'hFF, 23'd0};
      end
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      if (be >= 255) return {d[63], 8'hFF, 23'd0};
      if (be >= 1) begin
        rnd = d[28] & ((|d[27:0]) | d[29]);
        return {d[63], 31'({be[7:0], d[51:29]}) + 31'(rnd)};
      end
      // Below the normal range: shift into the subnormal field.
      sa = -(ue + 97);
      if (sa > 60) begin
        field = '0;
        rbit = 1'b0;
        sticky = 1'b1;
      end else begin
        field = sig >> sa;
        rbit = sa <= 53 ? sig[sa-1] : 1'b0;
        sticky = (64'(sig) & ((64'd1 << (sa - 1)) - 64'd1)) != 0;
      end
      rnd = rbit & (sticky | field[0]);
      return {d[63], 31'(field) + 31'(rnd)};
    endfunction

    // Fused multiply-add, rounded once: exact product, round-to-odd sum.
    function logic [31:0] fused_lane_update(logic [31:0] p, int m, logic [31:0] a);
      real         t;
      real         c;
      real         s;
      real         bv;
      real         err;
      logic [63:0] sb;
      t = single_to_real(p) * real'(m);
      c = single_to_real(a);
      s = t + c;
      bv = s - t;
      err = (t - (s - bv)) + (c - bv);
      sb = $realtobits(s);
      if (sb[62:52] != 11'h7FF && err != 0.0 && !sb[0]) begin
        sb = ((err > 0.0) == (s > 0.0)) ? sb + 64'd1 : sb - 64'd1;
        s = $bitstoreal(sb);
      end
      return real_to_single(s);
    endfunction

    function logic [31:0] add_pair(logic [31:0] a, logic [31:0] b);
      return real_to_single(single_to_real(a) + single_to_real(b));
    endfunction

    // Notes an accepted request and, on vector end, queues the expected result.
    function void note_request(logic [31:0] xb, logic [31:0] yl, logic [31:0] yh,
                               logic [31:0] dxb, logic [31:0] dyb, logic vend);
      logic [7:0]  byte_v;
      logic [31:0] scale;
      for (int k = 0; k < 4; k++) begin
        byte_v = xb[8*k +: 8];
        blk_sum += (int'(byte_v[3:0]) - 8) * int'($signed(yl[8*k +: 8]))
                 + (int'(byte_v[7:4]) - 8) * int'($signed(yh[8*k +: 8]));
      end
      if (item_idx + 1 >= ITEMS_PER_BLK || vend) begin
        scale = real_to_single(single_to_real(dxb) * single_to_real(dyb));
        lane_acc[lane_idx] = fused_lane_update(scale, blk_sum, lane_acc[lane_idx]);
        blk_sum = 0;
        item_idx = 0;
        lane_idx = (lane_idx + 1) % LANES;
      end else begin
        item_idx++;
      end
      if (vend) begin
        dot_q.push_back(add_pair(add_pair(lane_acc[0], lane_acc[1]),
                                 add_pair(lane_acc[2], lane_acc[3])));
        clear_state();
      end
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      seen++;
      if (dot_q.size() == 0) begin
        $error("dot_result_bits: no result expected, actual %h", got);
        fails++;
        return;
      end
      want = dot_q.pop_front();
      if (got !== want) begin
        $error("dot_result_bits: expected %h, actual %h", want, got);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  qdot_item_if   items_ch();
  qdot_result_if results_ch();

  quantized_q4_q8_block_dot dut (
    .clk(clk),
    .rst(rst),
    .items(items_ch.sink),
    .results(results_ch.source)
  );

  dot_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int sent = 0;
  int vectors = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("[quantized_q4_q8_block_dot] ERROR");
    $finish;
  end

  // Result side: random stalls, with a long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && results_ch.valid && results_ch.ready)
        sb.check_result(results_ch.dot_result_bits);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        results_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        results_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(7) == 0)
          stall_left = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 3);
      end
    end
  end

  function automatic int pick_gap();
    if (quiet) return 0;
    if ($urandom_range(9) == 0)
      return ($urandom_range(9) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 3);
    return 0;
  endfunction

  // Offers one request and waits for its acceptance.
  task automatic send(logic [31:0] xb, logic [31:0] yl, logic [31:0] yh,
                      logic [31:0] dxb, logic [31:0] dyb, logic vend);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      items_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_ch.valid          <= 1'b1;
    items_ch.x_nibble_bytes <= xb;
    items_ch.y_low_quants   <= yl;
    items_ch.y_high_quants  <= yh;
    items_ch.x_scale_bits   <= dxb;
    items_ch.y_scale_bits   <= dyb;
    items_ch.vector_end     <= vend;
    do @(posedge clk); while (!items_ch.ready);
    sb.note_request(xb, yl, yh, dxb, dyb, vend);
    sent++;
    if (vend) vectors++;
  endtask

  // A vector of len requests, with the same scales on every request.
  task automatic send_vector(int len, logic [31:0] xb, logic [31:0] y,
                             logic [31:0] dxb, logic [31:0] dyb);
    for (int i = 0; i < len; i++) send(xb, y, y, dxb, dyb, i == len - 1);
  endtask

  function automatic logic [31:0] rand_scale();
    if ($urandom_range(9) == 0) return $urandom;
    return {1'($urandom_range(1)), 8'($urandom_range(110, 140)), 23'($urandom)};
  endfunction

  task automatic send_random_vector(int len);
    for (int i = 0; i < len; i++)
      send($urandom, $urandom, $urandom, rand_scale(), rand_scale(), i == len - 1);
  endtask

  task automatic wait_drained();
    items_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int len;
    rst <= 1'b1;
    items_ch.valid          <= 1'b0;
    items_ch.x_nibble_bytes <= '0;
    items_ch.y_low_quants   <= '0;
    items_ch.y_high_quants  <= '0;
    items_ch.x_scale_bits   <= '0;
    items_ch.y_scale_bits   <= '0;
    items_ch.vector_end     <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: nibble and quant extremes, full and early-ended blocks,
    // subnormal, infinite, NaN and overflowing scales, signed zero scales.
    send_vector(4, 32'h0000_0000, 32'h7F7F_7F7F, 32'h3F80_0000, 32'h3F00_0000);
    send_vector(4, 32'hFFFF_FFFF, 32'h8080_8080, 32'hC000_0000, 32'h3F80_0000);
    send_vector(1, 32'h0F0F_F0F0, 32'h80FF_017F, 32'h0000_0001, 32'h4B00_0000);
    send_vector(2, 32'h1234_5678, 32'h9ABC_DEF0, 32'h7F80_0000, 32'h0000_0000);
    send_vector(1, 32'h0000_0000, 32'h7F7F_7F7F, 32'h7FA0_0000, 32'h3F80_0000);
    send_vector(1, 32'hFFFF_FFFF, 32'h7F7F_7F7F, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
    send_vector(8, 32'h8888_8888, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000);

    // Long hold-off on results while short vectors keep coming.
    wait_drained();
    hold_req = 1'b1;
    for (int v = 0; v < 6; v++) send_random_vector(2);
    // Pause until every result is back.
    wait_drained();

    // A stretch with no idling on either side.
    quiet = 1'b1;
    while (sent < 120) send_random_vector($urandom_range(1, 12));
    wait_drained();
    quiet = 1'b0;

    // Random vectors, mostly short, a few spanning many blocks.
    while (sent < 520) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
      send_random_vector(len);
      if ($urandom_range(15) == 0) wait_drained();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    $display("Sent %0d requests in %0d vectors; %0d results checked.",
             sent, vectors, sb.seen);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("[quantized_q4_q8_block_dot] OK");
    end else begin
      $display("[quantized_q4_q8_block_dot] ERROR");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/qdot_pkg.sv
hw/rtl/qdot_if.sv
hw/rtl/qdot_lane.sv
hw/rtl/qdot_fpu.sv
hw/rtl/quantized_q4_q8_block_dot.sv
dv/tb_quantized_q4_q8_block_dot.sv
